FILE: hdl/sqtm_pkg.sv
// sqtm_pkg: constants, word types and helpers for the sensor qualifier
// trimmed-mean block. No dependencies.
`default_nettype none
package sqtm_pkg;

   localparam int WINDOW     = 16;
   localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int ELEM_W     = 17;
   localparam int SUM_W      = ELEM_W + CNT_W;
   localparam int DCNT_W     = $clog2(SUM_W);
   localparam int FAIL_W     = 2;
   localparam int SUCC_W     = 3;
   localparam int FAIL_LIMIT = 3;
   localparam int SUCC_LIMIT = 5;
   localparam int TRIM_DIV   = 5;
   localparam int ADDR_W     = 3;

   typedef enum logic {
      CSR_CAL_OFFSET,
      CSR_TWO_CHANNEL
   } csr_index_type;

   typedef struct packed {
      logic               read_ok;
      logic signed [15:0] temp_value;
      logic               temp_present;
      logic [10:0]        hum_value;
      logic               hum_present;
   } req_word_type;

   typedef struct packed {
      logic               in_error;
      logic signed [15:0] temp_average;
      logic               temp_average_valid;
      logic [10:0]        hum_average;
      logic               hum_average_valid;
      logic               window_full;
      logic               new_data;
   } rsp_word_type;

   // entries dropped at each end of the sorted window
   function automatic logic [CNT_W-1:0] trim_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int k = 1; k <= WINDOW / TRIM_DIV; k++) begin
         if (n >= CNT_W'(TRIM_DIV * k)) c = c + 1'b1;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sensor_qualifier_trimmed_mean.sv
// sensor_qualifier_trimmed_mean: read qualification, sample windows and
// trimmed mean on one shared compare/add/divide datapath. Uses sqtm_pkg.
//
//  channel  | signals                                   | direction
//  req      | req_valid, req_ready, req_word            | in
//  rsp      | rsp_valid, rsp_ready, rsp_word            | out
//  csr      | psel penable pwrite paddr pwdata prdata pready | apb slave
//
// one word at a time; per window a start state, a load of each entry (plain
// mean) or a rank scan of each entry against all (trimmed, one comparator),
// a prep state, a restoring divide and a store state, between the accept and
// result states; a used humidity window follows; the rank scan takes longest
// a failed read or a read dropped in error goes from accept straight to result
// reset clears counters, flags and averages; window contents need none
// a result held on rsp stalls only the next word's result state
`default_nettype none
module sensor_qualifier_trimmed_mean (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  sqtm_pkg::req_word_type       req_word,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output sqtm_pkg::rsp_word_type       rsp_word,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [sqtm_pkg::ADDR_W-1:0]   paddr,
   input  wire [31:0]                   pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import sqtm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_LOAD, S_CMP, S_PREP, S_DIV, S_STORE, S_DONE
   } state_type;

   state_type                state_ff;
   logic signed [15:0]       temp_win_ff [WINDOW];
   logic [10:0]              hum_win_ff  [WINDOW];
   logic signed [15:0]       cal_offset_ff;
   logic                     two_channel_ff;
   logic [CNT_W-1:0]         temp_count_ff, hum_count_ff;
   logic [IDX_W-1:0]         temp_pos_ff, hum_pos_ff;
   logic [FAIL_W-1:0]        fail_run_ff;
   logic [SUCC_W-1:0]        success_run_ff;
   logic                     error_flag_ff, full_flag_ff, fresh_ff;
   logic signed [15:0]       temp_avg_ff;
   logic [10:0]              hum_avg_ff;
   logic                     temp_ok_ff, hum_ok_ff, hum_pend_ff, sel_hum_ff, trim_ff;
   logic [CNT_W-1:0]         n_ff, lo_ff, div_ff, rank_ff;
   logic [IDX_W-1:0]         i_ff, j_ff;
   logic signed [ELEM_W-1:0] key_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]         quo_ff;
   logic [CNT_W-1:0]         rem_ff;
   logic [DCNT_W-1:0]        dcnt_ff;
   logic                     neg_ff;
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_word_ff;

   logic                     accept;
   logic [SUCC_W-1:0]        succ_in;
   logic [FAIL_W-1:0]        fail_in;
   logic                     err_ok_in, err_fail_in, take, push_t, push_h;
   logic signed [ELEM_W-1:0] temp_raw;
   logic signed [15:0]       temp_sat;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [ELEM_W-1:0] rd_elem;
   logic                     less, last_i, last_j, incl, full_now;
   logic [CNT_W-1:0]         rank_in, n_in, lo_in;
   logic [CNT_W:0]           shifted;
   logic [CNT_W+1:0]         trial;
   logic [SUM_W-1:0]         quot;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index_type'(paddr[ADDR_W-1:2]))
         CSR_CAL_OFFSET:  prdata = {{16{cal_offset_ff[15]}}, cal_offset_ff};
         CSR_TWO_CHANNEL: prdata = {31'b0, two_channel_ff};
         default:         prdata = '0;
      endcase
   end

   // run counters and error state after this word, window pushes and saturated temperature
   always_comb begin
      succ_in     = (success_run_ff < SUCC_W'(SUCC_LIMIT)) ? success_run_ff + 1'b1
                                                            : success_run_ff;
      fail_in     = (fail_run_ff < FAIL_W'(FAIL_LIMIT)) ? fail_run_ff + 1'b1 : fail_run_ff;
      err_ok_in   = error_flag_ff && (succ_in < SUCC_W'(SUCC_LIMIT));
      err_fail_in = error_flag_ff || (fail_in >= FAIL_W'(FAIL_LIMIT));
      take        = req_word.read_ok && !err_ok_in;
      push_t      = take && req_word.temp_present;
      push_h      = take && two_channel_ff && req_word.hum_present;
      temp_raw    = ELEM_W'(req_word.temp_value) + ELEM_W'(cal_offset_ff);
      if (temp_raw[ELEM_W-1] != temp_raw[15]) begin
         temp_sat = temp_raw[ELEM_W-1] ? 16'sh8000 : 16'sh7fff;
      end else begin
         temp_sat = temp_raw[15:0];
      end
   end

   // shared datapath: one window read, one compare, one add, one divide step
   always_comb begin
      rd_addr  = (state_ff == S_LOAD) ? i_ff : j_ff;
      rd_elem  = sel_hum_ff ? $signed(ELEM_W'(hum_win_ff[rd_addr]))
                            : ELEM_W'(temp_win_ff[rd_addr]);
      // ties broken by position so every entry gets a distinct rank
      less     = (rd_elem < key_ff) || ((rd_elem == key_ff) && (j_ff < i_ff));
      rank_in  = rank_ff + CNT_W'(less);
      last_i   = (i_ff == IDX_W'(n_ff - 1'b1));
      last_j   = (j_ff == IDX_W'(n_ff - 1'b1));
      incl     = (rank_in >= lo_ff) && (rank_in < (n_ff - lo_ff));
      full_now = (temp_count_ff == CNT_W'(WINDOW));
      n_in     = sel_hum_ff ? hum_count_ff : temp_count_ff;
      lo_in    = full_now ? trim_count(n_in) : '0;
      shifted  = {rem_ff, quo_ff[SUM_W-1]};
      trial    = {1'b0, shifted} - {2'b0, div_ff};
      quot     = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (accept && push_t) temp_win_ff[temp_pos_ff] <= temp_sat;
      if (accept && push_h) hum_win_ff[hum_pos_ff]   <= req_word.hum_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cal_offset_ff  <= '0;
         two_channel_ff <= 1'b0;
         temp_count_ff  <= '0;
         hum_count_ff   <= '0;
         temp_pos_ff    <= '0;
         hum_pos_ff     <= '0;
         fail_run_ff    <= '0;
         success_run_ff <= '0;
         error_flag_ff  <= 1'b0;
         full_flag_ff   <= 1'b0;
         fresh_ff       <= 1'b0;
         temp_avg_ff    <= '0;
         hum_avg_ff     <= '0;
         temp_ok_ff     <= 1'b0;
         hum_ok_ff      <= 1'b0;
         hum_pend_ff    <= 1'b0;
         sel_hum_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            case (csr_index_type'(paddr[ADDR_W-1:2]))
               CSR_CAL_OFFSET:  cal_offset_ff  <= pwdata[15:0];
               CSR_TWO_CHANNEL: two_channel_ff <= pwdata[0];
               default: ;
            endcase
         end
         // the result state reloads the word itself
         if (rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  sel_hum_ff <= 1'b0;
                  if (req_word.read_ok) begin
                     fail_run_ff    <= '0;
                     success_run_ff <= succ_in;
                     error_flag_ff  <= err_ok_in;
                  end else begin
                     success_run_ff <= '0;
                     fail_run_ff    <= fail_in;
                     error_flag_ff  <= err_fail_in;
                  end
                  if (push_t) begin
                     temp_pos_ff <= (temp_pos_ff == IDX_W'(WINDOW - 1)) ? '0
                                                                       : temp_pos_ff + 1'b1;
                     if (temp_count_ff < CNT_W'(WINDOW)) temp_count_ff <= temp_count_ff + 1'b1;
                  end
                  if (push_h) begin
                     hum_pos_ff <= (hum_pos_ff == IDX_W'(WINDOW - 1)) ? '0 : hum_pos_ff + 1'b1;
                     if (hum_count_ff < CNT_W'(WINDOW)) hum_count_ff <= hum_count_ff + 1'b1;
                  end
                  if (take) begin
                     state_ff <= S_START;
                  end else begin
                     fresh_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_START: begin
               if (!sel_hum_ff && temp_count_ff == '0) begin
                  fresh_ff <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  if (!sel_hum_ff) begin
                     fresh_ff    <= 1'b1;
                     hum_pend_ff <= two_channel_ff && (hum_count_ff != '0);
                     if (full_now) full_flag_ff <= 1'b1;
                     if (full_now && two_channel_ff && hum_count_ff == '0) begin
                        hum_ok_ff  <= 1'b0;
                        hum_avg_ff <= '0;
                     end
                  end
                  n_ff     <= n_in;
                  lo_ff    <= lo_in;
                  div_ff   <= n_in - (lo_in << 1);
                  trim_ff  <= full_now;
                  i_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (trim_ff) begin
                  key_ff   <= rd_elem;
                  j_ff     <= '0;
                  rank_ff  <= '0;
                  state_ff <= S_CMP;
               end else begin
                  sum_ff <= sum_ff + SUM_W'(rd_elem);
                  if (last_i) state_ff <= S_PREP;
                  else i_ff <= i_ff + 1'b1;
               end
            end
            S_CMP: begin
               rank_ff <= rank_in;
               if (last_j) begin
                  if (incl) sum_ff <= sum_ff + SUM_W'(key_ff);
                  if (last_i) begin
                     state_ff <= S_PREP;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_LOAD;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_PREP: begin
               neg_ff   <= sum_ff[SUM_W-1];
               quo_ff   <= sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               if (!trial[CNT_W+1]) rem_ff <= trial[CNT_W-1:0];
               else rem_ff <= shifted[CNT_W-1:0];
               quo_ff <= {quo_ff[SUM_W-2:0], !trial[CNT_W+1]};
               if (dcnt_ff == DCNT_W'(SUM_W - 1)) state_ff <= S_STORE;
               else dcnt_ff <= dcnt_ff + 1'b1;
            end
            S_STORE: begin
               if (sel_hum_ff) begin
                  hum_avg_ff <= quot[10:0];
                  hum_ok_ff  <= 1'b1;
               end else begin
                  temp_avg_ff <= quot[15:0];
                  temp_ok_ff  <= 1'b1;
               end
               if (!sel_hum_ff && hum_pend_ff) begin
                  sel_hum_ff <= 1'b1;
                  state_ff   <= S_START;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                   <= 1'b1;
                  rsp_word_ff.in_error           <= error_flag_ff;
                  rsp_word_ff.temp_average       <= temp_ok_ff ? temp_avg_ff : '0;
                  rsp_word_ff.temp_average_valid <= temp_ok_ff;
                  rsp_word_ff.hum_average        <= hum_ok_ff ? hum_avg_ff : '0;
                  rsp_word_ff.hum_average_valid  <= hum_ok_ff;
                  rsp_word_ff.window_full        <= full_flag_ff;
                  rsp_word_ff.new_data           <= fresh_ff;
                  state_ff                       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_err_set: assert property (@(posedge clock) disable iff (reset)
      $rose(error_flag_ff) |-> fail_run_ff == FAIL_W'(FAIL_LIMIT))
      else $error("error state set without a full failure run");
   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(error_flag_ff) |-> success_run_ff == SUCC_W'(SUCC_LIMIT))
      else $error("error state cleared without a full success run");
   a_count: assert property (@(posedge clock) disable iff (reset)
      temp_count_ff <= CNT_W'(WINDOW) && hum_count_ff <= CNT_W'(WINDOW))
      else $error("window count beyond depth");
   a_hum_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START && sel_hum_ff) |-> two_channel_ff && hum_count_ff != '0)
      else $error("humidity mean started on an unused window");
   a_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (CNT_W'(j_ff) < n_ff && CNT_W'(i_ff) < n_ff))
      else $error("rank scan outside filled entries");

endmodule
`default_nettype wire

FILE: tb/sensor_qualifier_trimmed_mean_test.sv
// sensor_qualifier_trimmed_mean_test: self-checking bench for the sensor qualifier with
// trimmed-mean windows; predicts each result word and compares it field by field.
// Depends on sqtm_pkg and sensor_qualifier_trimmed_mean.
`timescale 1ns / 100ps
`default_nettype none
module sensor_qualifier_trimmed_mean_test;
   import sqtm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sensor_qualifier_trimmed_mean dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int mismatches = 0;
   bit idle_on = 1'b1;
   int hold_left = 0;
   int stall_left = 0;
   rsp_word_type expected_words[$];

   // predictor state
   logic signed [15:0] cal_offset = '0;
   bit two_ch = 1'b0;
   int temp_win[WINDOW];
   int hum_win[WINDOW];
   int temp_n = 0, hum_n = 0, temp_wp = 0, hum_wp = 0;
   int fail_n = 0, succ_n = 0;
   bit err_state = 1'b0, full_seen = 1'b0;
   int temp_avg = 0, hum_avg = 0;
   bit temp_ok = 1'b0, hum_ok = 1'b0;

   function automatic int window_average(input int vals[WINDOW], input int n, input bit trim);
      int buf_v[WINDOW];
      int key, j, lo, hi, sum;
      buf_v = vals;
      lo = 0;
      hi = n;
      sum = 0;
      if (trim) begin
         for (int i = 1; i < n; i++) begin
            key = buf_v[i];
            j = i;
            while (j > 0 && buf_v[j-1] > key) begin
               buf_v[j] = buf_v[j-1];
               j--;
            end
            buf_v[j] = key;
         end
         if (n >= 5) begin
            lo = n / 5;
            hi = n - lo;
         end
      end
      for (int i = lo; i < hi; i++) sum += buf_v[i];
      return sum / (hi - lo);
   endfunction

   function automatic rsp_word_type qualify_read(input req_word_type w);
      rsp_word_type r;
      int v;
      bit fresh;
      fresh = 1'b0;
      if (w.read_ok) begin
         fail_n = 0;
         if (succ_n < 5) succ_n++;
         if (err_state && succ_n >= 5) err_state = 1'b0;
         if (!err_state) begin
            if (w.temp_present) begin
               v = int'(w.temp_value) + int'(cal_offset);
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               temp_win[temp_wp] = v;
               temp_wp = (temp_wp + 1) % WINDOW;
               if (temp_n < WINDOW) temp_n++;
            end
            if (two_ch && w.hum_present) begin
               hum_win[hum_wp] = int'(w.hum_value);
               hum_wp = (hum_wp + 1) % WINDOW;
               if (hum_n < WINDOW) hum_n++;
            end
            if (temp_n > 0) begin
               if (temp_n >= WINDOW) begin
                  full_seen = 1'b1;
                  temp_avg = window_average(temp_win, temp_n, 1'b1);
                  temp_ok = 1'b1;
                  if (two_ch) begin
                     hum_ok = (hum_n > 0);
                     hum_avg = hum_ok ? window_average(hum_win, hum_n, 1'b1) : 0;
                  end
               end else begin
                  temp_avg = window_average(temp_win, temp_n, 1'b0);
                  temp_ok = 1'b1;
                  if (two_ch && hum_n > 0) begin
                     hum_avg = window_average(hum_win, hum_n, 1'b0);
                     hum_ok = 1'b1;
                  end
               end
               fresh = 1'b1;
            end
         end
      end else begin
         succ_n = 0;
         if (fail_n < 3) fail_n++;
         if (!err_state && fail_n >= 3) err_state = 1'b1;
      end
      r.in_error = err_state;
      r.temp_average = temp_ok ? 16'(temp_avg) : '0;
      r.temp_average_valid = temp_ok;
      r.hum_average = hum_ok ? 11'(hum_avg) : '0;
      r.hum_average_valid = hum_ok;
      r.window_full = full_seen;
      r.new_data = fresh;
      return r;
   endfunction

   function automatic req_word_type make_read(input bit ok, input int t, input bit tp,
                                              input int h, input bit hp);
      req_word_type w;
      w.read_ok = ok;
      w.temp_value = 16'(t);
      w.temp_present = tp;
      w.hum_value = 11'(h);
      w.hum_present = hp;
      return w;
   endfunction

   function automatic req_word_type random_read(input bit ok);
      req_word_type w;
      int t;
      case ($urandom_range(0, 7))
         0: t = 32767;
         1: t = -32768;
         2, 3: t = $urandom_range(0, 65535);
         default: t = $urandom_range(0, 1600) - 800;
      endcase
      w = make_read(ok, t, $urandom_range(0, 7) != 0,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(0, 1600),
                    $urandom_range(0, 5) != 0);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      expected_words = {expected_words, qualify_read(w)};
   endtask

   task automatic drain;
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (expected_words.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == CSR_CAL_OFFSET) cal_offset = value[15:0];
      else two_ch = value[0];
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // result side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_ready && rsp_valid) begin
         stall_left = idle_on ? $urandom_range(0, 19) : 0;
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %0h", $time, rsp_word);
            mismatches++;
         end else begin
            e = expected_words.pop_front();
            compare_field("in_error", e.in_error, rsp_word.in_error);
            compare_field("temp_average", e.temp_average, rsp_word.temp_average);
            compare_field("temp_average_valid", e.temp_average_valid,
                          rsp_word.temp_average_valid);
            compare_field("hum_average", e.hum_average, rsp_word.hum_average);
            compare_field("hum_average_valid", e.hum_average_valid,
                          rsp_word.hum_average_valid);
            compare_field("window_full", e.window_full, rsp_word.window_full);
            compare_field("new_data", e.new_data, rsp_word.new_data);
         end
      end
   end

   task automatic test_directed;
      // empty window, missing temperature: no update
      send_word(make_read(1, 100, 0, 0, 0));
      send_word(make_read(1, 32767, 1, 2047, 1));
      send_word(make_read(1, -32768, 1, 0, 1));
      // three failures set the error state, run counter saturates
      repeat (4) send_word(make_read(0, 5, 1, 5, 1));
      // successes in error are dropped until the fifth
      repeat (4) send_word(make_read(1, 1234, 1, 100, 1));
      send_word(make_read(1, 16, 1, 100, 1));
      // fill the temperature window, humidity disabled
      for (int i = 0; i < 14; i++) send_word(make_read(1, i * 37 - 200, 1, 700, 1));
      // full window, humidity window empty: humidity average invalid
      write_reg(CSR_TWO_CHANNEL, 32'd1);
      send_word(make_read(1, 0, 1, 0, 0));
      send_word(make_read(1, -5, 0, 1600, 1));
      send_word(make_read(1, 9, 1, 2047, 1));
      write_reg(CSR_CAL_OFFSET, 32'h0000_7FFF);
      send_word(make_read(1, 32767, 1, 3, 1));
      write_reg(CSR_CAL_OFFSET, 32'hFFFF_8000);
      send_word(make_read(1, -32768, 1, 0, 1));
      send_word(make_read(1, 32767, 1, 0, 1));
   endtask

   task automatic test_random_phases;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_TWO_CHANNEL, 32'($urandom_range(0, 1)));
         write_reg(CSR_CAL_OFFSET, (phase == 3) ? 32'h7FFF :
                   (phase == 5) ? 32'hFFFF_8000 : 32'($urandom_range(0, 65535)));
         idle_on = (phase % 3 != 1);
         for (int i = 0; i < 64; i++) begin
            if ($urandom_range(0, 14) == 0) begin
               repeat ($urandom_range(1, 4)) send_word(random_read(1'b0));
            end
            send_word(random_read(1'b1));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure;
      drain();
      @(negedge clock);
      hold_left = 3000;
      idle_on = 1'b0;
      @(posedge clock);
      repeat (12) send_word(random_read(1'b1));
      idle_on = 1'b1;
   endtask

   task automatic test_pause;
      repeat (10) send_word(random_read($urandom_range(0, 3) != 0));
      drain();
      repeat (10) send_word(random_read(1'b1));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_backpressure();
      test_pause();
      drain();
      repeat (700) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("[sensor_qualifier_trimmed_mean] OK");
      end else begin
         $display("[sensor_qualifier_trimmed_mean] ERROR");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("[sensor_qualifier_trimmed_mean] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
